// File: src/csw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_pkg: shared constants and table builders
// Widths, reset value and sigmoid table construction for the clamped SwiGLU
// activation pipeline.
// ----------------------------------------------------------------------------
package csw_pkg;

	localparam int DATA_WIDTH  = 16;
	localparam int OUT_WIDTH   = 24;
	localparam int LIMIT_WIDTH = 15;
	localparam int SIG_WIDTH   = 17;
	localparam int SIG_ENTRIES = 256;

	localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 15'd2560;
	localparam logic [SIG_WIDTH-1:0]   SIG_ONE     = 17'd65536;

	// sigmoid table spans [-8, 8) in Q8.8
	localparam logic signed [DATA_WIDTH-1:0] X_LOW  = -16'sd2048;
	localparam logic signed [DATA_WIDTH-1:0] X_HIGH = 16'sd2048;
	localparam int OFFS_WIDTH = 12;

	localparam logic [63:0] Q32_ONE        = 64'd4294967296;
	localparam logic [63:0] EXP_M1_Q32     = 64'd1580030169;
	localparam logic [63:0] EXP_M1_256_Q32 = 64'd4278222805;

	localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = 24'sh7FFFFF;
	localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = -24'sh800000;

	// Restoring long division, used only while building constant tables
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Q32.32 product, rounded half up
	function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = 128'(a) * 128'(b) + 128'(64'd2147483648);
		return p[95:32];
	endfunction

	// Sigmoid at the center of table entry k, Q1.16
	function automatic logic [SIG_WIDTH-1:0] sig_value(input int unsigned k,
			input int unsigned entries);
		logic [63:0] off;
		logic [63:0] e;
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] q;
		int x;
		int unsigned a;
		off = udiv64(64'(k) * 64'd4096 + 64'd2048, 64'(entries));
		x = int'(off) - 2048;
		a = (x < 0) ? unsigned'(-x) : unsigned'(x);
		e = Q32_ONE;
		for (int unsigned i = 0; i < (a >> 8); i++) begin
			e = q32_mul(e, EXP_M1_Q32);
		end
		for (int unsigned i = 0; i < (a & 32'd255); i++) begin
			e = q32_mul(e, EXP_M1_256_Q32);
		end
		den = Q32_ONE + e;
		num = (x >= 0) ? (64'd1 << 48) : (e << 16);
		q = udiv64(num + (den >> 1), den);
		return q[SIG_WIDTH-1:0];
	endfunction

endpackage

// File: src/csw_pair_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_pair_if: gate/up request channel
// Valid/ready channel carrying one signed Q8.8 gate/up pair.
// ----------------------------------------------------------------------------
interface csw_pair_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [csw_pkg::DATA_WIDTH-1:0]    gate_value;
	logic signed [csw_pkg::DATA_WIDTH-1:0]    up_value;

	modport source (output valid, output gate_value, output up_value, input ready);
	modport sink   (input valid, input gate_value, input up_value, output ready);
endinterface

// File: src/csw_act_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_act_if: activation result channel
// Valid/ready channel carrying one signed Q16.8 activation.
// ----------------------------------------------------------------------------
interface csw_act_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [csw_pkg::OUT_WIDTH-1:0]  activation_out;

	modport source (output valid, output activation_out, input ready);
	modport sink   (input valid, input activation_out, output ready);
endinterface

// File: src/csw_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_lookup: clamp and sigmoid lookup stages
// Stage 1 clamps gate and up and forms the table index; stage 2 reads the
// sigmoid table and applies the saturation ends.
// ----------------------------------------------------------------------------
module csw_lookup #(
	parameter int SIG_ENTRIES = csw_pkg::SIG_ENTRIES
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [csw_pkg::LIMIT_WIDTH-1:0]        limit,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [csw_pkg::DATA_WIDTH-1:0]  gate,
	input  logic signed [csw_pkg::DATA_WIDTH-1:0]  up,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [csw_pkg::DATA_WIDTH-1:0]  gate_out,
	output logic signed [csw_pkg::DATA_WIDTH-1:0]  up_out,
	output logic [csw_pkg::SIG_WIDTH-1:0]          sig_out
);

	localparam int IDX_W  = $clog2(SIG_ENTRIES);
	localparam int PROD_W = csw_pkg::OFFS_WIDTH + $clog2(SIG_ENTRIES + 1);

	logic [csw_pkg::SIG_WIDTH-1:0] sig_rom [SIG_ENTRIES];

	for (genvar k = 0; k < SIG_ENTRIES; k++) begin : g_rom
		localparam logic [csw_pkg::SIG_WIDTH-1:0] SigK = csw_pkg::sig_value(k, SIG_ENTRIES);
		assign sig_rom[k] = SigK;
	end

	logic signed [csw_pkg::DATA_WIDTH-1:0] lim_s, nlim_s, g_c, u_c;
	logic [csw_pkg::OFFS_WIDTH-1:0]        offs;
	logic [PROD_W-1:0]                     idx_prod;
	logic                                  ready_s1, ready_s2;

	logic                                  valid_s1;
	logic signed [csw_pkg::DATA_WIDTH-1:0] gate_s1, up_s1;
	logic                                  lo_s1, hi_s1;
	logic [IDX_W-1:0]                      idx_s1;

	logic                                  valid_s2;
	logic signed [csw_pkg::DATA_WIDTH-1:0] gate_s2, up_s2;
	logic [csw_pkg::SIG_WIDTH-1:0]         sig_s2;

	always_comb begin
		lim_s  = signed'({1'b0, limit});
		nlim_s = -lim_s;
		g_c    = (gate > lim_s) ? lim_s : gate;
		if (up > lim_s) begin
			u_c = lim_s;
		end else if (up < nlim_s) begin
			u_c = nlim_s;
		end else begin
			u_c = up;
		end
		offs     = csw_pkg::OFFS_WIDTH'(g_c - csw_pkg::X_LOW);
		idx_prod = PROD_W'(offs) * PROD_W'(SIG_ENTRIES);
	end

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			gate_s1 <= g_c;
			up_s1   <= u_c;
			lo_s1   <= g_c < csw_pkg::X_LOW;
			hi_s1   <= g_c >= csw_pkg::X_HIGH;
			idx_s1  <= idx_prod[csw_pkg::OFFS_WIDTH +: IDX_W];
		end
		if (ready_s2 && valid_s1) begin
			gate_s2 <= gate_s1;
			up_s2   <= up_s1;
			if (lo_s1) begin
				sig_s2 <= '0;
			end else if (hi_s1) begin
				sig_s2 <= csw_pkg::SIG_ONE;
			end else begin
				sig_s2 <= sig_rom[idx_s1];
			end
		end
	end

	assign out_valid = valid_s2;
	assign gate_out  = gate_s2;
	assign up_out    = up_s2;
	assign sig_out   = sig_s2;

	// an accepted request lands in stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && ready_s1) |=> valid_s1)
		else $error("accepted request missing from stage 1");

	// sigmoid never exceeds one
	a_sig_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (sig_s2 <= csw_pkg::SIG_ONE))
		else $error("sigmoid above one");

endmodule

// File: src/csw_product.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_product: product stages
// Stage 3 forms gate*sigmoid, stage 4 rounds it and multiplies by up,
// stage 5 rounds, saturates and holds the result for the sink.
// ----------------------------------------------------------------------------
module csw_product (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [csw_pkg::DATA_WIDTH-1:0]  gate,
	input  logic signed [csw_pkg::DATA_WIDTH-1:0]  up,
	input  logic [csw_pkg::SIG_WIDTH-1:0]          sig,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [csw_pkg::OUT_WIDTH-1:0]   result
);

	localparam int GS_W = csw_pkg::DATA_WIDTH + csw_pkg::SIG_WIDTH;   // Q9.24
	localparam int S1_W = GS_W - 16;                                  // Q9.8
	localparam int P_W  = S1_W + csw_pkg::DATA_WIDTH;                 // Q17.16
	localparam int R_W  = P_W - 8;                                    // Q17.8

	logic signed [GS_W:0]   gs_full;
	logic signed [GS_W-1:0] gs_rnd;
	logic signed [S1_W-1:0] s1_val;
	logic signed [P_W-1:0]  p_rnd;
	logic signed [R_W-1:0]  r_val;
	logic                   ready_s3, ready_s4, ready_s5;

	logic                                  valid_s3;
	logic signed [GS_W-1:0]                gs_s3;
	logic signed [csw_pkg::DATA_WIDTH-1:0] up_s3;

	logic                   valid_s4;
	logic signed [P_W-1:0]  p_s4;

	logic                                 valid_s5;
	logic signed [csw_pkg::OUT_WIDTH-1:0] res_s5;

	always_comb begin
		gs_full = gate * signed'({1'b0, sig});
		gs_rnd  = gs_s3 + GS_W'(33'sd32768);
		s1_val  = S1_W'(gs_rnd >>> 16);
		p_rnd   = p_s4 + P_W'(33'sd128);
		r_val   = R_W'(p_rnd >>> 8);
	end

	assign ready_s5 = !valid_s5 || out_ready;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign in_ready = ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s3) valid_s3 <= in_valid;
			if (ready_s4) valid_s4 <= valid_s3;
			if (ready_s5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) begin
			gs_s3 <= GS_W'(gs_full);
			up_s3 <= up;
		end
		if (ready_s4 && valid_s3) begin
			p_s4 <= P_W'(s1_val * up_s3);
		end
		if (ready_s5 && valid_s4) begin
			if (r_val > R_W'(csw_pkg::OUT_MAX)) begin
				res_s5 <= csw_pkg::OUT_MAX;
			end else if (r_val < R_W'(csw_pkg::OUT_MIN)) begin
				res_s5 <= csw_pkg::OUT_MIN;
			end else begin
				res_s5 <= csw_pkg::OUT_WIDTH'(r_val);
			end
		end
	end

	assign out_valid = valid_s5;
	assign result    = res_s5;

	// a held result is not overwritten while the sink stalls
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && !out_ready) |=> (valid_s5 && $stable(res_s5)))
		else $error("stalled result lost");

endmodule

// File: src/clamped_swiglu_activation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clamped_swiglu_activation: clamped SwiGLU activation
// Clamps a Q8.8 gate/up pair, then returns silu(gate)*up in Q16.8.
//
//   port      dir  carries
//   pair_in   in   gate_value, up_value (signed Q8.8)
//   act_out   out  activation_out (signed Q16.8)
//   cfg_wr_*  in   clamp_limit (unsigned Q7.8, 15 bits)
//
// One request per cycle unless the sink stalls; the stages are clamp, table,
// two products and output register.
// Each stage advances when the next one is empty or moving, so a stalled
// sink fills the five stages and then drops pair_in.ready.
// Reset clears all stage valid bits and sets clamp_limit to 10.0.
// ----------------------------------------------------------------------------
module clamped_swiglu_activation #(
	parameter int SIG_ENTRIES = csw_pkg::SIG_ENTRIES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [csw_pkg::LIMIT_WIDTH-1:0]  cfg_wr_data,
	csw_pair_if.sink                         pair_in,
	csw_act_if.source                        act_out
);

	localparam logic [2:0] DEPTH = 3'd5;

	logic [csw_pkg::LIMIT_WIDTH-1:0]        limit_q;
	logic                                   mid_valid, mid_ready;
	logic signed [csw_pkg::DATA_WIDTH-1:0]  mid_gate, mid_up;
	logic [csw_pkg::SIG_WIDTH-1:0]          mid_sig;
	logic [2:0]                             inflight_q;
	logic                                   in_fire, out_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= csw_pkg::LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	csw_lookup #(
		.SIG_ENTRIES (SIG_ENTRIES)
	) u_lookup (
		.clk       (clk),
		.arst_n    (arst_n),
		.limit     (limit_q),
		.in_valid  (pair_in.valid),
		.in_ready  (pair_in.ready),
		.gate      (pair_in.gate_value),
		.up        (pair_in.up_value),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.gate_out  (mid_gate),
		.up_out    (mid_up),
		.sig_out   (mid_sig)
	);

	csw_product u_product (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.gate      (mid_gate),
		.up        (mid_up),
		.sig       (mid_sig),
		.out_valid (act_out.valid),
		.out_ready (act_out.ready),
		.result    (act_out.activation_out)
	);

	// track requests in flight for the checks below
	assign in_fire  = pair_in.valid && pair_in.ready;
	assign out_fire = act_out.valid && act_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_fire && !out_fire) begin
			inflight_q <= inflight_q + 3'd1;
		end else if (out_fire && !in_fire) begin
			inflight_q <= inflight_q - 3'd1;
		end
	end

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= DEPTH)
		else $error("more requests in flight than stages");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		act_out.valid |-> (inflight_q != 3'd0))
		else $error("result without a request");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(inflight_q == DEPTH && !act_out.ready) |-> !pair_in.ready)
		else $error("request taken into a full pipeline");

endmodule

// File: bench/clamped_swiglu_activation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clamped_swiglu_activation_tb: self-checking bench for the clamped SwiGLU
// A directed table followed by random gate/up pairs under several clamp
// limits. Activations are predicted from a locally built sigmoid table and
// compared in order with what the block returns, under random source and
// sink stalls.
// ----------------------------------------------------------------------------
module clamped_swiglu_activation_tb;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 9;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_GAP       = 16;
	localparam int LONG_HOLD     = 80;
	localparam int HOLD_AT       = 150;
	localparam int RAND_PHASES   = 5;
	localparam int PHASE_PAIRS   = 150;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int N_ROWS        = 22;

	typedef logic signed [csw_pkg::DATA_WIDTH-1:0] q88_t;
	typedef logic signed [csw_pkg::OUT_WIDTH-1:0]  q168_t;
	typedef logic [csw_pkg::LIMIT_WIDTH-1:0]       limit_t;

	typedef struct packed {
		q88_t   gate;
		q88_t   up;
		limit_t limit;
		logic   fixed;
		q168_t  result;
	} pair_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en;
	limit_t cfg_wr_data;

	csw_pair_if pair_in ();
	csw_act_if  act_out ();

	clamped_swiglu_activation i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.pair_in     (pair_in),
		.act_out     (act_out)
	);

	logic [csw_pkg::SIG_WIDTH-1:0] sigmoid_table [csw_pkg::SIG_ENTRIES];
	limit_t clamp_model = csw_pkg::LIMIT_RESET;
	q168_t  pending_activations [$];
	int     n_sent = 0;
	int     n_checked = 0;
	int     n_errors = 0;
	int     cycle_count = 0;
	int     n_limits = 1;
	bit     sender_burst = 1'b0;
	bit     sink_burst = 1'b0;
	bit     long_hold_done = 1'b0;

	// fixed values: reset limit 10.0, then full range, one LSB, zero, then 10.0 again
	pair_row_t directed_rows [N_ROWS] = '{
		'{16'sd0,      16'sd0,      15'd2560,  1'b1, 24'sd0},
		'{16'sd32767,  16'sd32767,  15'd2560,  1'b1, 24'sd25600},
		'{16'sd32767,  -16'sd32768, 15'd2560,  1'b1, -24'sd25600},
		'{-16'sd32768, 16'sd32767,  15'd2560,  1'b1, 24'sd0},
		'{16'sd2048,   16'sd256,    15'd2560,  1'b1, 24'sd2048},
		'{16'sd2047,   16'sd256,    15'd2560,  1'b0, 24'sd0},
		'{-16'sd2048,  16'sd256,    15'd2560,  1'b0, 24'sd0},
		'{-16'sd2049,  16'sd32767,  15'd2560,  1'b1, 24'sd0},
		'{16'sd256,    -16'sd256,   15'd2560,  1'b0, 24'sd0},
		'{-16'sd1,     16'sd1,      15'd2560,  1'b0, 24'sd0},
		'{16'sd21845,  -16'sd21846, 15'd2560,  1'b0, 24'sd0},
		'{-16'sd21846, 16'sd21845,  15'd2560,  1'b0, 24'sd0},
		'{16'sd32767,  16'sd32767,  15'd32767, 1'b1, 24'sd4194048},
		'{16'sd32767,  -16'sd32768, 15'd32767, 1'b1, -24'sd4194048},
		'{-16'sd32768, -16'sd32768, 15'd32767, 1'b1, 24'sd0},
		'{16'sd1000,   -16'sd1000,  15'd32767, 1'b0, 24'sd0},
		'{16'sd32767,  16'sd32767,  15'd1,     1'b0, 24'sd0},
		'{-16'sd32768, -16'sd32768, 15'd1,     1'b1, 24'sd0},
		'{16'sd1,      -16'sd1,     15'd1,     1'b0, 24'sd0},
		'{16'sd32767,  16'sd32767,  15'd0,     1'b1, 24'sd0},
		'{-16'sd300,   16'sd500,    15'd0,     1'b1, 24'sd0},
		'{16'sd2559,   -16'sd2559,  15'd2560,  1'b0, 24'sd0}
	};

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// sigmoid at the center of table entry k, Q1.16
	function automatic logic [csw_pkg::SIG_WIDTH-1:0] sigmoid_at(input int k);
		longint x;
		logic [63:0] mag;
		logic [63:0] decay;
		logic [63:0] denom;
		logic [63:0] numer;
		logic [63:0] step;
		x = longint'(csw_pkg::X_LOW) + (longint'(k) * 4096 + 2048) / csw_pkg::SIG_ENTRIES;
		mag = (x < 0) ? -x : x;
		decay = csw_pkg::Q32_ONE;
		for (step = 0; step < (mag >> 8); step++)
			decay = (decay * csw_pkg::EXP_M1_Q32 + 64'd2147483648) >> 32;
		for (step = 0; step < (mag & 64'd255); step++)
			decay = (decay * csw_pkg::EXP_M1_256_Q32 + 64'd2147483648) >> 32;
		denom = csw_pkg::Q32_ONE + decay;
		numer = (x >= 0) ? (64'd1 << 48) : (decay << 16);
		return csw_pkg::SIG_WIDTH'((numer + denom / 2) / denom);
	endfunction

	function automatic q168_t swiglu_activation(input q88_t gate, input q88_t up,
			input limit_t limit);
		longint g;
		longint u;
		longint lim;
		longint sig;
		longint gated;
		longint prod;
		g = gate;
		u = up;
		lim = limit;
		if (g > lim) g = lim;
		if (u > lim) u = lim;
		if (u < -lim) u = -lim;
		if (g < csw_pkg::X_LOW)
			sig = 0;
		else if (g >= csw_pkg::X_HIGH)
			sig = csw_pkg::SIG_ONE;
		else
			sig = sigmoid_table[((g - csw_pkg::X_LOW) * csw_pkg::SIG_ENTRIES) / 4096];
		// both roundings are half up, i.e. floor after adding half an LSB
		gated = (g * sig + 32768) >>> 16;
		prod = (gated * u + 128) >>> 8;
		if (prod > csw_pkg::OUT_MAX) prod = csw_pkg::OUT_MAX;
		if (prod < csw_pkg::OUT_MIN) prod = csw_pkg::OUT_MIN;
		return prod[csw_pkg::OUT_WIDTH-1:0];
	endfunction

	// mix full range, the sigmoid table span, the clamp edge and small values
	function automatic q88_t random_q88(input limit_t limit);
		int v;
		case ($urandom_range(0, 3))
			0: v = int'($urandom);
			1: v = int'($urandom_range(0, 4200)) - 2100;
			2: v = (($urandom_range(0, 1) == 0) ? int'(limit) : -int'(limit))
				+ int'($urandom_range(0, 8)) - 4;
			default: v = int'($urandom_range(0, 1023)) - 512;
		endcase
		return v[csw_pkg::DATA_WIDTH-1:0];
	endfunction

	task automatic send_pair(input q88_t gate, input q88_t up, input logic fixed,
			input q168_t result);
		int gap;
		if (n_sent % 40 == 0)
			sender_burst = ($urandom_range(0, 3) == 0);
		gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			pair_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pair_in.valid      <= 1'b1;
		pair_in.gate_value <= gate;
		pair_in.up_value   <= up;
		do @(posedge clk); while (!pair_in.ready);
		pending_activations.push_back(fixed ? result : swiglu_activation(gate, up, clamp_model));
		n_sent++;
		@(negedge clk);
	endtask

	// hold the source and wait until the pipe is empty
	task automatic drain_results();
		pair_in.valid <= 1'b0;
		while (pending_activations.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_clamp_limit(input limit_t limit);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= limit;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		clamp_model = limit;
		n_limits++;
		@(negedge clk);
	endtask

	initial begin : act_sink
		int stall;
		int n_taken;
		q168_t want;
		n_taken = 0;
		act_out.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (n_taken % 40 == 0)
				sink_burst = ($urandom_range(0, 3) == 0);
			stall = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
			// one long hold so the pipe fills and back-pressures the source
			if (!long_hold_done && n_checked >= HOLD_AT) begin
				stall = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (stall > 0) begin
				act_out.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			act_out.ready <= 1'b1;
			do @(posedge clk); while (!act_out.valid);
			n_taken++;
			if (pending_activations.size() == 0) begin
				$error("activation_out: no request pending, got %0d", act_out.activation_out);
				n_errors++;
			end else begin
				want = pending_activations.pop_front();
				if (act_out.activation_out !== want) begin
					$error("activation_out: expected %0d, got %0d", want,
						act_out.activation_out);
					n_errors++;
				end
				n_checked++;
			end
			@(negedge clk);
		end
	end

	initial begin
		limit_t phase_limits [RAND_PHASES];
		limit_t lim;
		pair_row_t row;
		pair_in.valid      = 1'b0;
		pair_in.gate_value = '0;
		pair_in.up_value   = '0;
		cfg_wr_en          = 1'b0;
		cfg_wr_data        = '0;
		for (int k = 0; k < csw_pkg::SIG_ENTRIES; k++)
			sigmoid_table[k] = sigmoid_at(k);
		phase_limits[0] = 15'd32767;
		phase_limits[1] = 15'd1;
		phase_limits[2] = limit_t'($urandom_range(2, 32766));
		phase_limits[3] = 15'd256;
		phase_limits[4] = limit_t'($urandom_range(2, 32766));

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < N_ROWS; r++) begin
			row = directed_rows[r];
			if (row.limit != clamp_model)
				write_clamp_limit(row.limit);
			send_pair(row.gate, row.up, row.fixed, row.result);
		end

		for (int p = 0; p < RAND_PHASES; p++) begin
			lim = phase_limits[p];
			write_clamp_limit(lim);
			for (int i = 0; i < PHASE_PAIRS; i++) begin
				// pause the source once until everything has come back
				if (p == 2 && i == PHASE_PAIRS / 2)
					drain_results();
				send_pair(random_q88(lim), random_q88(lim), 1'b0, '0);
			end
		end

		drain_results();
		$display("Covered %0d pairs (%0d checked) over %0d clamp limits incl. 0, 1 and max,",
			n_sent, n_checked, n_limits);
		$display("with random stalls on both sides, a long sink hold and a full drain.");
		if (n_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
